### hw/rtl/keyed_stepping_rotor_cipher_unit_macros.svh
// Assertion macros shared by the rotor cipher RTL.
`ifndef KEYED_STEPPING_ROTOR_CIPHER_UNIT_MACROS_SVH
`define KEYED_STEPPING_ROTOR_CIPHER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define KRC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define KRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KRC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KRC_ASSERT(label, clk, rst_n, prop, msg)
`define KRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define KRC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/krc_pkg.sv
// Types and constants of the keyed stepping rotor cipher.
package krc_pkg;

    localparam int BYTE_W      = 8;
    localparam int PERM_DEPTH  = 256;
    localparam int CNT_W       = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int KEY_MAX_DEF = 256;

    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_AMOUNT  = 2'd2;

    localparam logic MODE_KEY = 1'b0;
    localparam logic MODE_ENC = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KS_WAIT,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J
    } state_t;

    // Access request to the rotor table store.
    typedef struct packed {
        logic              clr;
        logic              re;
        logic [BYTE_W-1:0] raddr;
        logic              we;
        logic [BYTE_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
    } perm_req_t;

endpackage

### hw/rtl/krc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module krc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/krc_perm_store.sv
// Rotor table store: RAM plus per-entry valid bits that make unwritten entries read as identity.
module krc_perm_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  krc_pkg::perm_req_t        req,
    output logic [krc_pkg::BYTE_W-1:0] rdata
);

    logic [krc_pkg::PERM_DEPTH-1:0] vld_reg;
    logic [krc_pkg::BYTE_W-1:0]     rd_addr_reg;
    logic                           rd_vld_reg;
    logic [krc_pkg::BYTE_W-1:0]     ram_q;

    krc_ram #(
        .WIDTH (krc_pkg::BYTE_W),
        .DEPTH (krc_pkg::PERM_DEPTH),
        .AW    (krc_pkg::BYTE_W)
    ) u_ram (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .re    (req.re),
        .raddr (req.raddr),
        .rdata (ram_q)
    );

    // Clearing the valid bits restores the identity permutation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (req.clr)
        begin
            vld_reg <= '0;
        end
        else if (req.we)
        begin
            vld_reg[req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_addr_reg <= req.raddr;
            rd_vld_reg  <= vld_reg[req.raddr];
        end
    end

    assign rdata = rd_vld_reg ? ram_q : rd_addr_reg;

endmodule

### hw/rtl/krc_rotor_step.sv
// Configuration registers and the rotor position and step counter.
module krc_rotor_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [krc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [krc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          step,
    input  logic                          load,
    output logic [krc_pkg::BYTE_W-1:0]    pos_next
);

    logic [krc_pkg::BYTE_W-1:0] start_offset_reg;
    logic [krc_pkg::CNT_W-1:0]  step_period_reg;
    logic [krc_pkg::BYTE_W-1:0] step_amount_reg;
    logic [krc_pkg::BYTE_W-1:0] position_reg;
    logic [krc_pkg::CNT_W-1:0]  counter_reg;
    logic [krc_pkg::CNT_W-1:0]  cnt_inc;
    logic                       advance;

    assign cnt_inc  = counter_reg + krc_pkg::CNT_W'(1);
    assign advance  = (step_period_reg != '0) && (cnt_inc == step_period_reg);
    assign pos_next = advance ? position_reg + step_amount_reg : position_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_offset_reg <= '0;
            step_period_reg  <= krc_pkg::CNT_W'(1);
            step_amount_reg  <= krc_pkg::BYTE_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                krc_pkg::CFG_START_OFFSET: start_offset_reg <= cfg_data[krc_pkg::BYTE_W-1:0];
                krc_pkg::CFG_STEP_PERIOD:  step_period_reg  <= cfg_data[krc_pkg::CNT_W-1:0];
                krc_pkg::CFG_STEP_AMOUNT:  step_amount_reg  <= cfg_data[krc_pkg::BYTE_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            counter_reg  <= '0;
        end
        else if (load)
        begin
            position_reg <= start_offset_reg;
            counter_reg  <= '0;
        end
        else if (step)
        begin
            position_reg <= pos_next;
            counter_reg  <= advance ? '0 : cnt_inc;
        end
    end

endmodule

### hw/rtl/keyed_stepping_rotor_cipher_unit.sv
// Top level of the keyed stepping rotor cipher: key gathering, key schedule and encipher pipeline.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | to block  | in_valid / in_ready   | mode, data_byte, last_key
//  out     | from block| out_valid / out_ready | out_byte
//  cfg     | to block  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Encipher items are taken one per cycle while no key schedule runs and no result is stalled;
// a result passes through the table RAM read register and then the output register.
// The final key byte starts the key schedule: a wait state until the encipher read register is
// empty, then the states read i, read j, write i and write j for each table entry on the single
// read port of the table RAM; no item is taken meanwhile.
// Reset needs no clearing pass: valid bits make the table read as identity.
// A stalled result holds one item in the RAM read register and one in the output register.
`include "keyed_stepping_rotor_cipher_unit_macros.svh"

module keyed_stepping_rotor_cipher_unit #(
    parameter int KEY_MAX = krc_pkg::KEY_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [krc_pkg::BYTE_W-1:0]     data_byte,
    input  logic                           last_key,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [krc_pkg::BYTE_W-1:0]     out_byte,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [krc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [krc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int LEN_W  = $clog2(KEY_MAX + 1);

    krc_pkg::state_t    state_reg;
    krc_pkg::state_t    state_next;
    krc_pkg::perm_req_t perm_req;

    logic [krc_pkg::BYTE_W-1:0] perm_rdata;
    logic [krc_pkg::BYTE_W-1:0] key_q;
    logic [krc_pkg::BYTE_W-1:0] pos_next;

    logic in_fire;
    logic enc_fire;
    logic key_fire;
    logic last_fire;

    logic p1_valid_reg;
    logic p1_move;
    logic out_valid_reg;
    logic [krc_pkg::BYTE_W-1:0] out_byte_reg;

    logic [LEN_W-1:0] key_len_reg;
    logic [LEN_W-1:0] key_n_reg;
    logic [LEN_W-1:0] len_inc;
    logic [LEN_W-1:0] k_reg;
    logic [LEN_W-1:0] k_inc;
    logic             key_room;
    logic             key_we;
    logic             key_re;

    logic [krc_pkg::BYTE_W-1:0] i_reg;
    logic [krc_pkg::BYTE_W-1:0] j_reg;
    logic [krc_pkg::BYTE_W-1:0] ti_reg;
    logic [krc_pkg::BYTE_W-1:0] j_sum;

    assign in_fire   = in_valid && in_ready;
    assign enc_fire  = in_fire && (mode == krc_pkg::MODE_ENC);
    assign key_fire  = in_fire && (mode == krc_pkg::MODE_KEY);
    assign last_fire = key_fire && last_key;

    assign p1_move   = p1_valid_reg && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    assign key_room = key_len_reg < LEN_W'(KEY_MAX);
    assign key_we   = key_fire && key_room;
    assign len_inc  = key_room ? key_len_reg + LEN_W'(1) : key_len_reg;
    assign k_inc    = k_reg + LEN_W'(1);
    assign j_sum    = j_reg + perm_rdata + key_q;

    krc_perm_store u_perm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (perm_req),
        .rdata (perm_rdata)
    );

    krc_ram #(
        .WIDTH (krc_pkg::BYTE_W),
        .DEPTH (KEY_MAX),
        .AW    (KEY_AW)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_len_reg[KEY_AW-1:0]),
        .wdata (data_byte),
        .re    (key_re),
        .raddr (k_reg[KEY_AW-1:0]),
        .rdata (key_q)
    );

    krc_rotor_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (enc_fire),
        .load      (last_fire),
        .pos_next  (pos_next)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            krc_pkg::ST_IDLE:
            begin
                if (last_fire)
                begin
                    state_next = krc_pkg::ST_KS_WAIT;
                end
            end
            // The schedule shares the table read register with the encipher pipeline.
            krc_pkg::ST_KS_WAIT:
            begin
                if (!p1_valid_reg)
                begin
                    state_next = krc_pkg::ST_RD_I;
                end
            end
            krc_pkg::ST_RD_I: state_next = krc_pkg::ST_RD_J;
            krc_pkg::ST_RD_J: state_next = krc_pkg::ST_WR_I;
            krc_pkg::ST_WR_I: state_next = krc_pkg::ST_WR_J;
            krc_pkg::ST_WR_J:
            begin
                if (i_reg == '1)
                begin
                    state_next = krc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = krc_pkg::ST_RD_I;
                end
            end
            default: state_next = krc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        key_re         = 1'b0;
        perm_req       = '0;
        perm_req.raddr = i_reg;
        perm_req.waddr = i_reg;
        perm_req.wdata = perm_rdata;
        case (state_reg)
            krc_pkg::ST_IDLE:
            begin
                in_ready       = !p1_valid_reg || p1_move;
                perm_req.re    = enc_fire;
                perm_req.raddr = data_byte + pos_next;
                perm_req.clr   = last_fire;
            end
            krc_pkg::ST_RD_I:
            begin
                perm_req.re = 1'b1;
                key_re      = 1'b1;
            end
            krc_pkg::ST_RD_J:
            begin
                perm_req.re    = 1'b1;
                perm_req.raddr = j_sum;
            end
            krc_pkg::ST_WR_I:
            begin
                perm_req.we = 1'b1;
            end
            krc_pkg::ST_WR_J:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = j_reg;
                perm_req.wdata = ti_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= krc_pkg::ST_IDLE;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_len_reg   <= '0;
            key_n_reg     <= LEN_W'(1);
        end
        else
        begin
            state_reg <= state_next;

            if (enc_fire)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_move)
            begin
                p1_valid_reg <= 1'b0;
            end

            if (p1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (last_fire)
            begin
                key_len_reg <= '0;
                key_n_reg   <= (len_inc == '0) ? LEN_W'(1) : len_inc;
            end
            else if (key_fire)
            begin
                key_len_reg <= len_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_move)
        begin
            out_byte_reg <= perm_rdata;
        end

        if (last_fire)
        begin
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end

        if (state_reg == krc_pkg::ST_RD_J)
        begin
            ti_reg <= perm_rdata;
            j_reg  <= j_sum;
        end

        if (state_reg == krc_pkg::ST_WR_J)
        begin
            i_reg <= i_reg + krc_pkg::BYTE_W'(1);
            k_reg <= (k_inc == key_n_reg) ? '0 : k_inc;
        end
    end

    `KRC_ASSERT(a_perm_rw_excl, clk, rst_n, !(perm_req.re && perm_req.we), "table read and write collide")
    `KRC_ASSERT_NXT(a_last_starts_ks, clk, rst_n, last_fire, state_reg == krc_pkg::ST_KS_WAIT, "key schedule not started")
    `KRC_ASSERT_IMP(a_key_idx_range, clk, rst_n, state_reg == krc_pkg::ST_RD_I, k_reg < key_n_reg, "key index out of range")
    `KRC_ASSERT_NXT(a_enc_in_flight, clk, rst_n, enc_fire, p1_valid_reg, "encipher item lost")
    `KRC_ASSERT_IMP(a_rdj_after_rdi, clk, rst_n, state_reg == krc_pkg::ST_RD_J, $past(state_reg) == krc_pkg::ST_RD_I, "schedule step order broken")

endmodule
